FILE: design/stl_pkg.sv
// Package with the item types, token kinds and lexer tables.
`timescale 1ns / 1ps
package stl_pkg;

  localparam int OffsetBits = 16;
  localparam int KeywordChars = 8;
  localparam int MaxTokens = 4;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start_res;
    logic [15:0] length;
    logic [30:0] int_value;
    logic        last_of_run;
  } out_item_t;

  localparam logic [5:0] K_IDENT   = 6'd0;
  localparam logic [5:0] K_DEF     = 6'd6;
  localparam logic [5:0] K_IF      = 6'd10;
  localparam logic [5:0] K_WHILE   = 6'd11;
  localparam logic [5:0] K_INTC    = 6'd16;
  localparam logic [5:0] K_NEWLINE = 6'd17;
  localparam logic [5:0] K_DOT     = 6'd18;
  localparam logic [5:0] K_COLON   = 6'd19;
  localparam logic [5:0] K_COMMA   = 6'd20;
  localparam logic [5:0] K_OPAREN  = 6'd21;
  localparam logic [5:0] K_CPAREN  = 6'd22;
  localparam logic [5:0] K_OBRACE  = 6'd23;
  localparam logic [5:0] K_CBRACE  = 6'd24;
  localparam logic [5:0] K_OBRACK  = 6'd25;
  localparam logic [5:0] K_CBRACK  = 6'd26;
  localparam logic [5:0] K_PLUS    = 6'd28;
  localparam logic [5:0] K_MINUS   = 6'd29;
  localparam logic [5:0] K_STAR    = 6'd30;
  localparam logic [5:0] K_SLASH   = 6'd31;
  localparam logic [5:0] K_PERCENT = 6'd32;
  localparam logic [5:0] K_EQ      = 6'd36;
  localparam logic [5:0] K_NE      = 6'd37;
  localparam logic [5:0] K_NEGATE  = 6'd46;
  localparam logic [5:0] K_ELIF    = 6'd47;
  localparam logic [5:0] K_ELSE    = 6'd48;
  localparam logic [5:0] K_NONE    = 6'd63;

  // Pending modes: 1..8 are the one-character operators = < > & | + - !
  localparam logic [3:0] P_NONE  = 4'd0;
  localparam logic [3:0] P_MINUS = 4'd7;
  localparam logic [3:0] P_SLASH = 4'd9;
  localparam logic [3:0] P_WORD  = 4'd10;
  localparam logic [3:0] P_NUMD  = 4'd11;
  localparam logic [3:0] P_NUMT  = 4'd12;
  localparam logic [3:0] P_ELSE4 = 4'd13;
  localparam logic [3:0] P_ELSE5 = 4'd14;
  localparam logic [3:0] P_ELSE6 = 4'd15;

  localparam logic [1:0] C_NONE  = 2'd0;
  localparam logic [1:0] C_LINE  = 2'd1;
  localparam logic [1:0] C_BLOCK = 2'd2;
  localparam logic [1:0] C_STAR  = 2'd3;

  function automatic logic [7:0] op_second(input logic [3:0] p);
    case (p)
      4'd4:    op_second = "&";
      4'd5:    op_second = "|";
      4'd6:    op_second = "+";
      4'd7:    op_second = "-";
      default: op_second = "=";
    endcase
  endfunction

  function automatic logic [5:0] op_two(input logic [3:0] p);
    case (p)
      4'd1: op_two = 6'd36;
      4'd2: op_two = 6'd41;
      4'd3: op_two = 6'd43;
      4'd4: op_two = 6'd38;
      4'd5: op_two = 6'd39;
      4'd6: op_two = 6'd33;
      4'd7: op_two = 6'd34;
      default: op_two = 6'd37;
    endcase
  endfunction

  function automatic logic [5:0] op_one(input logic [3:0] p);
    case (p)
      4'd1: op_one = 6'd27;
      4'd2: op_one = 6'd40;
      4'd3: op_one = 6'd42;
      4'd4: op_one = 6'd44;
      4'd5: op_one = 6'd45;
      4'd6: op_one = 6'd28;
      4'd7: op_one = 6'd29;
      default: op_one = 6'd35;
    endcase
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    is_delim = c inside {" ", 8'h0a, 8'h09, ",", ":", ";", 8'h0d, "$", "{", "}", "(",
                         ")", "*", "/", "-", "+", "=", "!", ">", "<", "&", "|", "."};
  endfunction

  // Keyword lookup over the first eight characters, left aligned.
  function automatic logic [5:0] kw_kind(input logic [63:0] w, input logic [15:0] len);
    logic [5:0] k;
    k = K_IDENT;
    case (len)
      16'd2: if (w[63:48] == "if") k = 6'd10;
      16'd3: begin
        case (w[63:40])
          "var": k = 6'd5;
          "def": k = 6'd6;
          "INT": k = 6'd8;
          "for": k = 6'd12;
          default: k = K_IDENT;
        endcase
      end
      16'd4: begin
        case (w[63:32])
          "bool": k = 6'd1;
          "type": k = 6'd2;
          "void": k = 6'd9;
          "true": k = 6'd14;
          default: k = K_IDENT;
        endcase
      end
      16'd5: begin
        case (w[63:24])
          "break": k = 6'd3;
          "while": k = 6'd11;
          "false": k = 6'd13;
          default: k = K_IDENT;
        endcase
      end
      16'd6: if (w[63:16] == "return") k = 6'd7;
      16'd7: if (w[63:8] == "package") k = 6'd15;
      16'd8: if (w == "continue") k = 6'd4;
      default: k = K_IDENT;
    endcase
    kw_kind = k;
  endfunction

endpackage

FILE: design/script_token_lexer_core.sv
// Streaming script lexer: one character per item in, up to four tokens out.
`timescale 1ns / 1ps
// One character item is accepted per cycle while input ready is high. Its
// tokens (zero to four) are computed in one pass of logic after the input
// register and written into a small token queue; the output side pops one
// token per cycle while the receiver is ready. Input ready drops only while
// the queue, after taking the tokens of the item already in the input
// register, lacks room for a worst-case burst of four. With a ready receiver
// and at most one token per character the block takes one character per
// cycle; a burst of several tokens can stall the input.
module script_token_lexer_core import stl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int QDepth = 8;
  localparam int QBits = 3;

  // Input register.
  logic     s_valid;
  in_item_t s_item;

  // Lexer state.
  logic [15:0] offset;
  logic [1:0]  comment_mode;
  logic [3:0]  pending_mode;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [7:0]  word_prefix [KeywordChars];
  logic [30:0] number_accum;
  logic        number_overflow;
  logic [5:0]  last_kind;

  // Token queue.
  out_item_t   queue [QDepth];
  logic [QBits-1:0] rd_ptr, wr_ptr;
  logic [QBits:0]   count;

  // Combinational step results.
  logic [15:0] offset_next, token_start_next, token_length_next;
  logic [1:0]  comment_mode_next;
  logic [3:0]  pending_mode_next;
  logic [30:0] number_accum_next;
  logic        number_overflow_next;
  logic [5:0]  last_kind_next;
  logic [7:0]  wp_next [KeywordChars];
  out_item_t   tok [MaxTokens];
  logic [2:0]  ntok;

  logic [15:0] room;
  logic        pop;
  logic        push;

  assign pop = out_valid && out_ready;
  assign push = s_valid;
  assign room = 16'(QDepth) - 16'(count);
  // The queue must take the tokens of the item in the input register plus a
  // worst-case burst from the item accepted now.
  assign in_ready = (room >= 16'(MaxTokens) + (s_valid ? 16'(ntok) : 16'd0));

  always_comb begin
    logic [7:0]  c;
    logic        eoi;
    logic        consumed;
    logic [3:0]  p;
    logic [63:0] wflat;
    logic [34:0] v;
    logic [3:0]  d;

    c = s_item.ch;
    eoi = s_item.end_of_input;
    offset_next = offset;
    token_start_next = token_start;
    token_length_next = token_length;
    comment_mode_next = comment_mode;
    pending_mode_next = pending_mode;
    number_accum_next = number_accum;
    number_overflow_next = number_overflow;
    last_kind_next = last_kind;
    wp_next = word_prefix;
    ntok = 3'd0;
    consumed = 1'b0;
    p = P_NONE;
    wflat = '0;
    v = '0;
    d = '0;
    for (int i = 0; i < MaxTokens; i++) tok[i] = '0;

    if (comment_mode == C_LINE) begin
      if (c == 8'h0a || c == 8'h0d) begin
        tok[ntok[1:0]] = '{kind: K_NEWLINE, start_res: offset, length: 16'd1,
                           int_value: '0, last_of_run: 1'b0};
        ntok = ntok + 3'd1;
        comment_mode_next = C_NONE;
      end
    end else if (comment_mode != C_NONE) begin
      if (c == "*") comment_mode_next = C_STAR;
      else if (comment_mode == C_STAR && c == "/") comment_mode_next = C_NONE;
      else comment_mode_next = C_BLOCK;
    end else begin
      // Offer the character to the pending token.
      p = pending_mode;
      if (p >= 4'd1 && p <= 4'd8) begin
        pending_mode_next = P_NONE;
        if (c == op_second(p)) begin
          tok[ntok[1:0]] = '{kind: op_two(p), start_res: token_start, length: 16'd2,
                             int_value: '0, last_of_run: 1'b0};
          ntok = ntok + 3'd1;
          consumed = 1'b1;
        end else begin
          tok[ntok[1:0]] = '{kind: op_one(p), start_res: token_start, length: 16'd1,
                             int_value: '0, last_of_run: 1'b0};
          if (p == P_MINUS && (last_kind == K_OPAREN || last_kind == K_PLUS ||
              last_kind == K_MINUS || last_kind == K_STAR || last_kind == K_SLASH ||
              last_kind == K_PERCENT || last_kind == K_EQ || last_kind == K_NE ||
              last_kind == K_IF || last_kind == K_ELIF || last_kind == K_ELSE ||
              last_kind == K_WHILE))
            tok[ntok[1:0]].kind = K_NEGATE;
          ntok = ntok + 3'd1;
        end
      end else begin
        case (p)
          P_SLASH: begin
            pending_mode_next = P_NONE;
            if (c == "/") begin
              comment_mode_next = C_LINE;
              consumed = 1'b1;
            end else if (c == "*") begin
              comment_mode_next = C_BLOCK;
              consumed = 1'b1;
            end else begin
              tok[ntok[1:0]] = '{kind: K_SLASH, start_res: token_start, length: 16'd1,
                                 int_value: '0, last_of_run: 1'b0};
              ntok = ntok + 3'd1;
            end
          end
          P_NUMD, P_NUMT: begin
            if (is_delim(c)) begin
              tok[ntok[1:0]] = '{kind: K_INTC, start_res: token_start,
                                 length: token_length,
                                 int_value: number_overflow ? '0 : number_accum,
                                 last_of_run: 1'b0};
              ntok = ntok + 3'd1;
              pending_mode_next = P_NONE;
            end else begin
              consumed = 1'b1;
              if (token_length != 16'hffff) token_length_next = token_length + 16'd1;
              if (p == P_NUMD && c >= "0" && c <= "9") begin
                d = 4'(c - "0");
                v = {number_accum, 3'b000} + {2'b00, number_accum, 1'b0} + 35'(d);
                if (!number_overflow) begin
                  if (v > 35'd2147483647) number_overflow_next = 1'b1;
                  else number_accum_next = v[30:0];
                end
              end else begin
                pending_mode_next = P_NUMT;
              end
            end
          end
          P_ELSE4, P_ELSE5: begin
            if (p == P_ELSE4 && c == " ") begin
              pending_mode_next = P_ELSE5;
              consumed = 1'b1;
            end else if (p == P_ELSE5 && c == "i") begin
              pending_mode_next = P_ELSE6;
              consumed = 1'b1;
            end else begin
              tok[ntok[1:0]] = '{kind: K_ELSE, start_res: token_start, length: 16'd4,
                                 int_value: '0, last_of_run: 1'b0};
              ntok = ntok + 3'd1;
              pending_mode_next = P_NONE;
            end
          end
          P_ELSE6: begin
            if (c == "f") begin
              tok[ntok[1:0]] = '{kind: K_ELIF, start_res: token_start, length: 16'd7,
                                 int_value: '0, last_of_run: 1'b0};
              ntok = ntok + 3'd1;
              pending_mode_next = P_NONE;
              consumed = 1'b1;
            end else begin
              tok[ntok[1:0]] = '{kind: K_ELSE, start_res: token_start, length: 16'd4,
                                 int_value: '0, last_of_run: 1'b0};
              ntok = ntok + 3'd1;
              // The trailing "i" starts a fresh word five characters on.
              token_start_next = token_start + 16'd5;
              wp_next[0] = "i";
              token_length_next = 16'd1;
              pending_mode_next = P_WORD;
              if (is_delim(c)) begin
                tok[ntok[1:0]] = '{kind: K_IDENT, start_res: token_start + 16'd5,
                                   length: 16'd1, int_value: '0, last_of_run: 1'b0};
                ntok = ntok + 3'd1;
                pending_mode_next = P_NONE;
              end else begin
                wp_next[1] = c;
                token_length_next = 16'd2;
                consumed = 1'b1;
              end
            end
          end
          P_WORD: begin
            if (token_length == 16'd1 && word_prefix[0] == "e" && c == "l") begin
              wp_next[1] = c;
              token_length_next = 16'd2;
              consumed = 1'b1;
            end else if (token_length == 16'd2 && word_prefix[0] == "e" &&
                         word_prefix[1] == "l" && (c == "s" || c == "i")) begin
              wp_next[2] = c;
              token_length_next = 16'd3;
              consumed = 1'b1;
            end else if (token_length == 16'd3 && word_prefix[0] == "e" &&
                         word_prefix[1] == "l" && word_prefix[2] == "s" && c == "e") begin
              pending_mode_next = P_ELSE4;
              consumed = 1'b1;
            end else if (token_length == 16'd3 && word_prefix[0] == "e" &&
                         word_prefix[1] == "l" && word_prefix[2] == "i" && c == "f") begin
              tok[ntok[1:0]] = '{kind: K_ELIF, start_res: token_start, length: 16'd4,
                                 int_value: '0, last_of_run: 1'b0};
              ntok = ntok + 3'd1;
              pending_mode_next = P_NONE;
              consumed = 1'b1;
            end else if (is_delim(c)) begin
              for (int i = 0; i < KeywordChars; i++)
                wflat[63-8*i -: 8] = word_prefix[i];
              tok[ntok[1:0]] = '{kind: kw_kind(wflat, token_length),
                                 start_res: token_start, length: token_length,
                                 int_value: '0, last_of_run: 1'b0};
              ntok = ntok + 3'd1;
              pending_mode_next = P_NONE;
            end else begin
              if (token_length < 16'(KeywordChars)) wp_next[token_length[2:0]] = c;
              if (token_length != 16'hffff) token_length_next = token_length + 16'd1;
              consumed = 1'b1;
            end
          end
          default: consumed = 1'b0;
        endcase
      end

      if (!consumed) begin
        // The character starts something new.
        p = P_NONE;
        tok[ntok[1:0]] = '{kind: K_IDENT, start_res: offset, length: 16'd1,
                           int_value: '0, last_of_run: 1'b0};
        case (c)
          " ", 8'h09: ;
          8'h0a, 8'h0d, ";": tok[ntok[1:0]].kind = K_NEWLINE;
          ".": tok[ntok[1:0]].kind = K_DOT;
          ":": tok[ntok[1:0]].kind = K_COLON;
          ",": tok[ntok[1:0]].kind = K_COMMA;
          "$": tok[ntok[1:0]].kind = K_DEF;
          "(": tok[ntok[1:0]].kind = K_OPAREN;
          ")": tok[ntok[1:0]].kind = K_CPAREN;
          "{": tok[ntok[1:0]].kind = K_OBRACE;
          "}": tok[ntok[1:0]].kind = K_CBRACE;
          "[": tok[ntok[1:0]].kind = K_OBRACK;
          "]": tok[ntok[1:0]].kind = K_CBRACK;
          "*": tok[ntok[1:0]].kind = K_STAR;
          "%": tok[ntok[1:0]].kind = K_PERCENT;
          "=": p = 4'd1;
          "<": p = 4'd2;
          ">": p = 4'd3;
          "&": p = 4'd4;
          "|": p = 4'd5;
          "+": p = 4'd6;
          "-": p = 4'd7;
          "!": p = 4'd8;
          "/": p = P_SLASH;
          default: p = P_WORD;
        endcase
        if (c == " " || c == 8'h09) begin
          // Whitespace: nothing happens.
        end else if (c inside {8'h0a, 8'h0d, ";", ".", ":", ",", "$", "(", ")", "{",
                               "}", "[", "]", "*", "%"}) begin
          ntok = ntok + 3'd1;
        end else begin
          token_start_next = offset;
          if (p != P_WORD) begin
            pending_mode_next = p;
          end else if (c >= "0" && c <= "9") begin
            token_length_next = 16'd1;
            number_accum_next = 31'(c - "0");
            number_overflow_next = 1'b0;
            pending_mode_next = P_NUMD;
          end else begin
            wp_next[0] = c;
            token_length_next = 16'd1;
            pending_mode_next = P_WORD;
          end
        end
      end
    end

    // last_kind as it stands before the flush.
    if (ntok != 3'd0) last_kind_next = tok[ntok[1:0] - 2'd1].kind;

    if (eoi) begin
      p = pending_mode_next;
      if (p >= 4'd1 && p <= 4'd8) begin
        tok[ntok[1:0]] = '{kind: op_one(p), start_res: token_start_next, length: 16'd1,
                           int_value: '0, last_of_run: 1'b0};
        if (p == P_MINUS && (last_kind_next == K_OPAREN || last_kind_next == K_PLUS ||
            last_kind_next == K_MINUS || last_kind_next == K_STAR ||
            last_kind_next == K_SLASH || last_kind_next == K_PERCENT ||
            last_kind_next == K_EQ || last_kind_next == K_NE ||
            last_kind_next == K_IF || last_kind_next == K_ELIF ||
            last_kind_next == K_ELSE || last_kind_next == K_WHILE))
          tok[ntok[1:0]].kind = K_NEGATE;
        ntok = ntok + 3'd1;
      end else begin
        case (p)
          P_SLASH: begin
            tok[ntok[1:0]] = '{kind: K_SLASH, start_res: token_start_next,
                               length: 16'd1, int_value: '0, last_of_run: 1'b0};
            ntok = ntok + 3'd1;
          end
          P_WORD: begin
            for (int i = 0; i < KeywordChars; i++)
              wflat[63-8*i -: 8] = wp_next[i];
            tok[ntok[1:0]] = '{kind: kw_kind(wflat, token_length_next),
                               start_res: token_start_next, length: token_length_next,
                               int_value: '0, last_of_run: 1'b0};
            ntok = ntok + 3'd1;
          end
          P_NUMD, P_NUMT: begin
            tok[ntok[1:0]] = '{kind: K_INTC, start_res: token_start_next,
                               length: token_length_next,
                               int_value: number_overflow_next ? '0 : number_accum_next,
                               last_of_run: 1'b0};
            ntok = ntok + 3'd1;
          end
          P_ELSE4, P_ELSE5, P_ELSE6: begin
            tok[ntok[1:0]] = '{kind: K_ELSE, start_res: token_start_next, length: 16'd4,
                               int_value: '0, last_of_run: 1'b0};
            ntok = ntok + 3'd1;
            if (p == P_ELSE6) begin
              tok[ntok[1:0]] = '{kind: K_IDENT, start_res: token_start_next + 16'd5,
                                 length: 16'd1, int_value: '0, last_of_run: 1'b0};
              ntok = ntok + 3'd1;
              token_start_next = token_start_next + 16'd5;
              token_length_next = 16'd1;
              wp_next[0] = "i";
            end
          end
          default: ;
        endcase
      end
      pending_mode_next = P_NONE;
      offset_next = '0;
      comment_mode_next = C_NONE;
      if (ntok != 3'd0) last_kind_next = tok[ntok[1:0] - 2'd1].kind;
    end else begin
      offset_next = offset + 16'd1;
    end
    if (ntok != 3'd0) tok[ntok[1:0] - 2'd1].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      offset <= '0;
      comment_mode <= C_NONE;
      pending_mode <= P_NONE;
      token_start <= '0;
      token_length <= '0;
      number_accum <= '0;
      number_overflow <= 1'b0;
      last_kind <= K_NONE;
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s_valid <= 1'b1;
        s_item <= in_data;
      end else begin
        s_valid <= 1'b0;
      end
      if (push) begin
        offset <= offset_next;
        comment_mode <= comment_mode_next;
        pending_mode <= pending_mode_next;
        token_start <= token_start_next;
        token_length <= token_length_next;
        word_prefix <= wp_next;
        number_accum <= number_accum_next;
        number_overflow <= number_overflow_next;
        last_kind <= last_kind_next;
        for (int i = 0; i < MaxTokens; i++)
          if (3'(i) < ntok) queue[wr_ptr + QBits'(i)] <= tok[i];
        wr_ptr <= wr_ptr + QBits'(ntok);
      end
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (push ? (QBits+1)'(ntok) : '0) - (QBits+1)'(pop);
    end
  end

  assign out_valid = (count != '0);
  assign out_data = queue[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QBits+1)'(QDepth)) else $error("token queue overflow");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    {1'b0, wr_ptr - rd_ptr} == count || count == (QBits+1)'(QDepth))
    else $error("queue pointers disagree with count");
  a_eoi_clears: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_item.end_of_input |=> offset == '0 && pending_mode == P_NONE &&
    comment_mode == C_NONE) else $error("end of input left state behind");
  a_ntok_max: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> ntok <= 3'(MaxTokens)) else $error("too many tokens for one item");

endmodule
